/* hw/rtl/turn_order_rotation_list_core_macros.svh */
`ifndef TURN_ORDER_ROTATION_LIST_CORE_MACROS_SVH
`define TURN_ORDER_ROTATION_LIST_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define TORL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define TORL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/torl_pkg.sv */
`default_nettype none
package torl_pkg;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_APPEND    = 3'd1;
  localparam logic [2:0] OP_INS_OWNER = 3'd2;
  localparam logic [2:0] OP_INS_INDEX = 3'd3;
  localparam logic [2:0] OP_REMOVE    = 3'd4;
  localparam logic [2:0] OP_ADVANCE   = 3'd5;
  localparam logic [2:0] OP_LOOKUP    = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [2:0] RD_CUR     = 3'd0;
  localparam logic [2:0] RD_NEXT    = 3'd1;
  localparam logic [2:0] RD_PREV    = 3'd2;
  localparam logic [2:0] RD_NEXT_OF = 3'd3;
  localparam logic [2:0] RD_PREV_OF = 3'd4;

  localparam int         TURN_W    = 16;
  localparam logic [15:0] TURN_MAX  = 16'hFFFF;
  localparam logic [15:0] TURN_INIT = 16'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_FRD, S_FCMP, S_PLAN, S_SRD, S_SWR, S_UPD, S_ORD, S_OCAP, S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic srch_start;
    logic post;
    logic srch_rd;
    logic srch_cmp;
    logic plan;
    logic sh_rd;
    logic sh_wr;
    logic upd;
    logic o_rd;
    logic o_cap;
  } cmd_t;

  typedef struct packed {
    logic pre_srch;
    logic srch_end;
    logic hit;
    logic more;
    logic ocap_last;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/torl_ctrl.sv */
`default_nettype none
module torl_ctrl
  import torl_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire  logic out_ready,
  input  wire  sts_t sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   post_r, post_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      post_r  <= post_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    post_nxt  = post_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PRE;
      S_PRE: begin
        post_nxt  = 1'b0;
        state_nxt = sts.pre_srch ? S_FRD : S_PLAN;
      end
      S_FRD: begin
        if (sts.srch_end) state_nxt = post_r ? S_ORD : S_PLAN;
        else state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (sts.hit) state_nxt = post_r ? S_ORD : S_PLAN;
        else state_nxt = S_FRD;
      end
      S_PLAN: state_nxt = S_SRD;
      S_SRD:  state_nxt = sts.more ? S_SWR : S_UPD;
      S_SWR:  state_nxt = S_SRD;
      S_UPD: begin
        post_nxt  = 1'b1;
        state_nxt = S_FRD;
      end
      S_ORD:  state_nxt = S_OCAP;
      S_OCAP: state_nxt = sts.ocap_last ? S_OUT : S_ORD;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_PRE:  cmd.srch_start = sts.pre_srch;
      S_FRD:  cmd.srch_rd = !sts.srch_end;
      S_FCMP: cmd.srch_cmp = 1'b1;
      S_PLAN: cmd.plan = 1'b1;
      S_SRD:  cmd.sh_rd = sts.more;
      S_SWR:  cmd.sh_wr = 1'b1;
      S_UPD: begin
        cmd.upd        = 1'b1;
        cmd.srch_start = 1'b1;
        cmd.post       = 1'b1;
      end
      S_ORD:  cmd.o_rd = 1'b1;
      S_OCAP: cmd.o_cap = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/torl_dp.sv */
`default_nettype none
`include "turn_order_rotation_list_core_macros.svh"
module torl_dp
  import torl_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int ID_BITS     = 16
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  cmd_t              cmd,
  output sts_t                    sts,
  input  wire  logic [2:0]        in_operation,
  input  wire  logic [15:0]       in_entity,
  input  wire  logic [15:0]       in_owner_entity,
  input  wire  logic [6:0]        in_slot_index,
  output logic [1:0]              out_status,
  output logic                    out_wrapped,
  output logic                    out_current_valid,
  output logic [15:0]             out_current_entity,
  output logic [15:0]             out_next_entity,
  output logic [15:0]             out_previous_entity,
  output logic signed [7:0]       out_position,
  output logic [6:0]              out_count,
  output logic [15:0]             out_turn,
  output logic [6:0]              out_turn_order,
  output logic [15:0]             out_next_of_entity,
  output logic [15:0]             out_previous_of_entity
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int CW   = CNTW + 2;
  localparam int SW   = (CNTW > 7) ? CNTW : 7;
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_ENTRIES);

  logic [ID_BITS-1:0] mem [MAX_ENTRIES];
  logic [ID_BITS-1:0] rdata_r;

  logic [2:0]          op_r;
  logic [ID_BITS-1:0]  ent_r, own_r, key_r;
  logic [6:0]          slot_r;
  logic [CNTW-1:0]     cnt_r, ptr_r, pos_r;
  logic signed [CW-1:0] cur_r;
  logic [TURN_W-1:0]   turn_r;
  logic [AW-1:0]       fidx_r;
  logic                found_r, ins_r, rem_r, wrapped_r, cvalid_r;
  logic [1:0]          status_r;
  logic [2:0]          k_r;
  logic [ID_BITS-1:0]  cur_e_r, nxt_e_r, prv_e_r, nof_r, pof_r;

  logic signed [CW-1:0] cnt_s, fidx_s, pos_s, cur_inc, cur_dec, cur_rem;
  logic [CNTW-1:0]      src, slot_clamp;
  logic                 full, cvalid, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [ID_BITS-1:0]   wr_data;

  function automatic logic [AW-1:0] wrap_idx(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] n);
    logic signed [CW-1:0] y;
    begin
      y = x;
      if (y < 0) y = y + n;
      if (y < 0) y = y + n;
      if (y >= n) y = y - n;
      if (y >= n) y = y - n;
      return y[AW-1:0];
    end
  endfunction

  always_comb begin
    cnt_s   = $signed({2'b00, cnt_r});
    fidx_s  = $signed({{(CW-AW){1'b0}}, fidx_r});
    pos_s   = $signed({2'b00, pos_r});
    cur_inc = cur_r + CW'(1);
    cur_dec = cur_r - CW'(1);
    cur_rem = (fidx_s <= cur_r) ? cur_dec : cur_r;
    full    = (cnt_r == FULL_CNT);
    cvalid  = (cur_r >= 0) && (cur_r < cnt_s);
    src     = ins_r ? (ptr_r - CNTW'(1)) : (ptr_r + CNTW'(1));
    slot_clamp = (SW'(slot_r) > SW'(cnt_r)) ? cnt_r : CNTW'(slot_r);

    sts.pre_srch  = (op_r == OP_INS_OWNER) || ((op_r == OP_REMOVE) && (cnt_r != '0));
    sts.srch_end  = (ptr_r >= cnt_r);
    sts.hit       = (rdata_r == key_r);
    sts.more      = ins_r ? (ptr_r > pos_r) : (rem_r ? ((ptr_r + CNTW'(1)) < cnt_r) : 1'b0);
    sts.ocap_last = (k_r == RD_PREV_OF);

    rd_addr = ptr_r[AW-1:0];
    if (cmd.sh_rd) begin
      rd_addr = src[AW-1:0];
    end else if (cmd.o_rd) begin
      case (k_r)
        RD_CUR:     rd_addr = cur_r[AW-1:0];
        RD_NEXT:    rd_addr = wrap_idx(cur_inc, cnt_s);
        RD_PREV:    rd_addr = wrap_idx(cur_dec, cnt_s);
        RD_NEXT_OF: rd_addr = wrap_idx(fidx_s + CW'(1), cnt_s);
        RD_PREV_OF: rd_addr = wrap_idx(fidx_s - CW'(1), cnt_s);
        default:    rd_addr = ptr_r[AW-1:0];
      endcase
    end

    wr_en   = cmd.sh_wr || (cmd.upd && ins_r);
    wr_addr = cmd.sh_wr ? ptr_r[AW-1:0] : pos_r[AW-1:0];
    wr_data = cmd.sh_wr ? rdata_r : ent_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r      <= in_operation;
      ent_r     <= ID_BITS'(in_entity);
      own_r     <= ID_BITS'(in_owner_entity);
      slot_r    <= in_slot_index;
      status_r  <= ST_OK;
      wrapped_r <= 1'b0;
      ins_r     <= 1'b0;
      rem_r     <= 1'b0;
    end
    if (cmd.upd && (op_r == OP_ADVANCE) && (cur_inc >= cnt_s)) wrapped_r <= 1'b1;
    if (cmd.srch_start) begin
      ptr_r   <= '0;
      found_r <= 1'b0;
      key_r   <= ((op_r == OP_INS_OWNER) && !cmd.post) ? own_r : ent_r;
    end
    if (cmd.srch_cmp) begin
      if (sts.hit) begin
        found_r <= 1'b1;
        fidx_r  <= ptr_r[AW-1:0];
      end else begin
        ptr_r <= ptr_r + CNTW'(1);
      end
    end
    if (cmd.plan) begin
      k_r <= RD_CUR;
      case (op_r)
        OP_APPEND: begin
          if (full) status_r <= ST_FULL;
          else begin
            ins_r <= 1'b1;
            pos_r <= cnt_r;
            ptr_r <= cnt_r;
          end
        end
        OP_INS_OWNER: begin
          if (!found_r) status_r <= ST_NOTFOUND;
          else if (full) status_r <= ST_FULL;
          else begin
            ins_r <= 1'b1;
            pos_r <= CNTW'(fidx_r) + CNTW'(1);
            ptr_r <= cnt_r;
          end
        end
        OP_INS_INDEX: begin
          if (full) status_r <= ST_FULL;
          else begin
            ins_r <= 1'b1;
            pos_r <= slot_clamp;
            ptr_r <= cnt_r;
          end
        end
        OP_REMOVE: begin
          if (cnt_r == '0) status_r <= ST_EMPTY;
          else if (!found_r) status_r <= ST_NOTFOUND;
          else begin
            rem_r <= 1'b1;
            ptr_r <= CNTW'(fidx_r);
          end
        end
        OP_ADVANCE, OP_LOOKUP: if (cnt_r == '0) status_r <= ST_EMPTY;
        default: ;
      endcase
    end
    if (cmd.sh_wr) ptr_r <= src;
    if (cmd.o_cap) begin
      k_r <= k_r + 3'd1;
      case (k_r)
        RD_CUR: begin
          cvalid_r <= cvalid;
          cur_e_r  <= cvalid ? rdata_r : '0;
          if ((op_r == OP_LOOKUP) && (status_r == ST_OK) && !found_r) status_r <= ST_NOTFOUND;
        end
        RD_NEXT:    nxt_e_r <= (cnt_r != '0) ? rdata_r : '0;
        RD_PREV:    prv_e_r <= (cnt_r != '0) ? rdata_r : '0;
        RD_NEXT_OF: nof_r   <= found_r ? rdata_r : '0;
        RD_PREV_OF: pof_r   <= found_r ? rdata_r : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cur_r  <= '0;
      turn_r <= TURN_INIT;
    end else if (cmd.upd) begin
      case (op_r)
        OP_CLEAR: begin
          cnt_r  <= '0;
          cur_r  <= '0;
          turn_r <= TURN_INIT;
        end
        OP_APPEND, OP_INS_OWNER: if (ins_r) cnt_r <= cnt_r + CNTW'(1);
        OP_INS_INDEX: begin
          if (ins_r) begin
            cnt_r <= cnt_r + CNTW'(1);
            if (pos_s <= cur_r) cur_r <= cur_inc;
          end
        end
        OP_REMOVE: begin
          if (rem_r) begin
            cnt_r <= cnt_r - CNTW'(1);
            if (cur_rem == -CW'(1)) begin
              cur_r <= cnt_s - CW'(2);
              if (turn_r != '0) turn_r <= turn_r - TURN_W'(1);
            end else begin
              cur_r <= cur_rem;
            end
          end
        end
        OP_ADVANCE: begin
          if (cur_inc >= cnt_s) begin
            if (turn_r != TURN_MAX) turn_r <= turn_r + TURN_W'(1);
            if (cnt_r == '0) cur_r <= '0;
            else cur_r <= $signed({{(CW-AW){1'b0}}, wrap_idx(cur_inc, cnt_s)});
          end else begin
            cur_r <= cur_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_status             = status_r;
  assign out_wrapped            = wrapped_r;
  assign out_current_valid      = cvalid_r;
  assign out_current_entity     = 16'(cur_e_r);
  assign out_next_entity        = 16'(nxt_e_r);
  assign out_previous_entity    = 16'(prv_e_r);
  assign out_position           = 8'(cur_r);
  assign out_count              = 7'(cnt_r);
  assign out_turn               = turn_r;
  assign out_turn_order         = found_r ? 7'({1'b0, fidx_r} + {{AW{1'b0}}, 1'b1}) : 7'd0;
  assign out_next_of_entity     = 16'(nof_r);
  assign out_previous_of_entity = 16'(pof_r);

  `TORL_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= FULL_CNT, "entry count above capacity")
  `TORL_ASSERT_IMP(a_cur_range, clk, rst_n, 1'b1, (cur_r >= -CW'(1)) && (cur_r <= cnt_s), "cursor out of range")
  `TORL_ASSERT_NXT(a_clear, clk, rst_n, cmd.upd && (op_r == OP_CLEAR), (cnt_r == '0) && (turn_r == TURN_INIT) && (cur_r == '0), "clear did not reset state")

endmodule
`default_nettype wire

/* hw/rtl/turn_order_rotation_list_core.sv */
// channel | handshake            | beat payload
// in      | in_valid / in_ready  | operation, entity, owner_entity, slot_index
// out     | out_valid / out_ready| status, wrapped, cursor view, count, turn, lookup view
//
// One beat at a time. A search reads and compares list entries in turn, a shift moves
// entries one by one, and the output reads then fill the result view.
// Reset: synchronous active-low rst_n; empty list, cursor 0, turn 1.
// A stalled result holds the block; in_ready stays low until it is taken.
`default_nettype none
module turn_order_rotation_list_core
  import torl_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int ID_BITS     = 16
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [2:0]  in_operation,
  input  wire  logic [15:0] in_entity,
  input  wire  logic [15:0] in_owner_entity,
  input  wire  logic [6:0]  in_slot_index,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [1:0]        out_status,
  output logic              out_wrapped,
  output logic              out_current_valid,
  output logic [15:0]       out_current_entity,
  output logic [15:0]       out_next_entity,
  output logic [15:0]       out_previous_entity,
  output logic signed [7:0] out_position,
  output logic [6:0]        out_count,
  output logic [15:0]       out_turn,
  output logic [6:0]        out_turn_order,
  output logic [15:0]       out_next_of_entity,
  output logic [15:0]       out_previous_of_entity
);

  cmd_t cmd;
  sts_t sts;

  torl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  torl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_operation           (in_operation),
    .in_entity              (in_entity),
    .in_owner_entity        (in_owner_entity),
    .in_slot_index          (in_slot_index),
    .out_status             (out_status),
    .out_wrapped            (out_wrapped),
    .out_current_valid      (out_current_valid),
    .out_current_entity     (out_current_entity),
    .out_next_entity        (out_next_entity),
    .out_previous_entity    (out_previous_entity),
    .out_position           (out_position),
    .out_count              (out_count),
    .out_turn               (out_turn),
    .out_turn_order         (out_turn_order),
    .out_next_of_entity     (out_next_of_entity),
    .out_previous_of_entity (out_previous_of_entity)
  );

endmodule
`default_nettype wire
